// File: design/multi_servo_pulse_scheduler_macros.svh
// Assertion macros for the servo pulse scheduler.
// Included by the top level; relies on clk and arst_n in the including module.
`ifndef MULTI_SERVO_PULSE_SCHEDULER_MACROS_SVH
`define MULTI_SERVO_PULSE_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSPS_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/msps_pkg.sv
// Shared constants and codes for the multichannel servo pulse scheduler.
// No dependencies.
package msps_pkg;

	localparam logic [15:0] SERVO_PINS = 16'hFF00;
	localparam int unsigned PIN_SHIFT = 8;

	localparam logic [2:0] KIND_SET_TARGET = 3'd0;
	localparam logic [2:0] KIND_RESCHEDULE = 3'd1;
	localparam logic [2:0] KIND_EXPIRY     = 3'd2;
	localparam logic [2:0] KIND_START      = 3'd3;
	localparam logic [2:0] KIND_STOP       = 3'd4;

	localparam logic [2:0] REG_PERIOD     = 3'd0;
	localparam logic [2:0] REG_MIN_PULSE  = 3'd1;
	localparam logic [2:0] REG_MAX_PULSE  = 3'd2;
	localparam logic [2:0] REG_RESOLUTION = 3'd3;
	localparam logic [2:0] REG_ENABLE     = 3'd4;
	localparam logic [2:0] REG_ALWAYS_ON  = 3'd5;
	localparam logic [2:0] REG_ALWAYS_OFF = 3'd6;
	localparam logic [2:0] REG_AUTO_APPLY = 3'd7;

	localparam logic [15:0] RST_PERIOD     = 16'd20000;
	localparam logic [15:0] RST_MIN_PULSE  = 16'd1000;
	localparam logic [15:0] RST_MAX_PULSE  = 16'd2000;
	localparam logic [15:0] RST_RESOLUTION = 16'd512;
	localparam logic [7:0]  RST_ENABLE     = 8'hFF;

endpackage

// File: design/multi_servo_pulse_scheduler.sv
// Servo pulse scheduler: event handling plus an iterative reschedule sequencer.
// Depends on msps_pkg and multi_servo_pulse_scheduler_macros.svh.
// Every word gives its registered result in the cycle after acceptance; a new word waits
// until the previous result has been taken.
// A reschedule (after an expiry that enters the gap with work pending) keeps the input
// stalled while it runs the shared 32-step restoring divider (skipped when the resolution
// is zero) and the one-pair-per-cycle sort.
// Reset runs that same reschedule on the reset settings before the first word is taken.
module multi_servo_pulse_scheduler
	import msps_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [2:0]  channel,
	input  logic [15:0] target,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pins_set,
	output logic [15:0] pins_clear,
	output logic [15:0] next_interval,
	output logic        in_gap,
	output logic        running,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	`include "multi_servo_pulse_scheduler_macros.svh"

	localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TIW = $clog2(CHANNELS + 1);
	localparam int MIW = $clog2(CHANNELS + 2);
	localparam logic [MIW-1:0] LAST_CH = MIW'(CHANNELS - 1);
	localparam logic [TIW-1:0] NCH = TIW'(CHANNELS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DIV, ST_STORE, ST_SORT, ST_MERGE, ST_GATE
	} state_t;

	state_t state_q;

	logic [15:0] period_q, min_q, max_q, res_q, on_q, off_q;
	logic [7:0]  enable_q;
	logic        auto_q;

	logic [15:0] snap_min_q, snap_max_q, snap_res_q, live_period_q, live_on_q, live_off_q;
	logic [31:0] snap_diff_q;
	logic [7:0]  snap_en_q;

	logic [15:0] targets_q [CHANNELS];
	logic [15:0] times_q   [CHANNELS+1];
	logic [15:0] masks_q   [CHANNELS+2];

	logic [TIW-1:0] step_q;
	logic [15:0]    cur_time_q;
	logic           run_q, gap_q, changed_q, pending_q;

	logic [MIW-1:0] i_q, top_q;
	logic [4:0]     div_cnt_q;
	logic [31:0]    p_q;
	logic [15:0]    rem_q;

	logic        out_valid_q, gap_out_q, run_out_q;
	logic [15:0] set_out_q, clr_out_q, nxt_out_q;

	// Event path.
	logic           accept;
	logic [MIW-1:0] step_p1;
	logic [15:0]    nxt_time;
	logic           at_end, gap_enter;
	logic [15:0]    start_set;

	// Reschedule datapath.
	logic [31:0] prod;
	logic [16:0] rem_n;
	logic        div_ge;
	logic [16:0] rem_sub;
	logic [15:0] sum_w, width_w;
	logic        swap;

	assign accept    = in_valid && in_ready;
	assign step_p1   = MIW'(step_q) + MIW'(1);
	assign nxt_time  = times_q[step_p1[TIW-1:0]];
	assign at_end    = gap_q || (step_q >= NCH) || (cur_time_q >= live_period_q);
	assign gap_enter = (step_p1 >= MIW'(CHANNELS)) || (nxt_time >= live_period_q);
	assign start_set = (masks_q[0] | live_on_q) & ~live_off_q;

	assign prod    = 32'(targets_q[i_q[CW-1:0]]) * snap_diff_q;
	assign rem_n   = {rem_q, p_q[31]};
	assign div_ge  = rem_n >= {1'b0, snap_res_q};
	assign rem_sub = rem_n - {1'b0, snap_res_q};
	assign sum_w   = p_q[15:0] + snap_min_q;
	always_comb begin
		if (snap_res_q == 16'd0) begin
			width_w = snap_max_q;
		end else if (sum_w > snap_max_q) begin
			width_w = snap_max_q;
		end else begin
			width_w = sum_w;
		end
	end
	assign swap = times_q[i_q[TIW-1:0]] > times_q[TIW'(i_q + MIW'(1))];

	assign in_ready      = (state_q == ST_IDLE) && !out_valid_q;
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign pins_set      = set_out_q;
	assign pins_clear    = clr_out_q;
	assign next_interval = nxt_out_q;
	assign in_gap        = gap_out_q;
	assign running       = run_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RST_PERIOD;
			min_q    <= RST_MIN_PULSE;
			max_q    <= RST_MAX_PULSE;
			res_q    <= RST_RESOLUTION;
			enable_q <= RST_ENABLE;
			on_q     <= 16'd0;
			off_q    <= 16'd0;
			auto_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PERIOD:     period_q <= cfg_data;
				REG_MIN_PULSE:  min_q    <= cfg_data;
				REG_MAX_PULSE:  max_q    <= cfg_data;
				REG_RESOLUTION: res_q    <= cfg_data;
				REG_ENABLE:     enable_q <= cfg_data[7:0];
				REG_ALWAYS_ON:  on_q     <= cfg_data;
				REG_ALWAYS_OFF: off_q    <= cfg_data;
				REG_AUTO_APPLY: auto_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_MUL;
			step_q        <= '0;
			run_q         <= 1'b0;
			gap_q         <= 1'b0;
			changed_q     <= 1'b0;
			pending_q     <= 1'b0;
			i_q           <= '0;
			top_q         <= '0;
			div_cnt_q     <= '0;
			out_valid_q   <= 1'b0;
			snap_min_q    <= RST_MIN_PULSE;
			snap_max_q    <= RST_MAX_PULSE;
			snap_res_q    <= RST_RESOLUTION;
			snap_diff_q   <= 32'(RST_MAX_PULSE) - 32'(RST_MIN_PULSE);
			snap_en_q     <= RST_ENABLE;
			live_period_q <= RST_PERIOD;
			live_on_q     <= 16'd0;
			live_off_q    <= 16'd0;
			for (int k = 0; k < CHANNELS; k++) begin
				targets_q[k] <= 16'd0;
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						out_valid_q <= 1'b1;
						set_out_q   <= 16'd0;
						clr_out_q   <= 16'd0;
						nxt_out_q   <= 16'd0;
						gap_out_q   <= gap_q;
						run_out_q   <= run_q;
						case (kind)
							KIND_SET_TARGET: begin
								if (32'(channel) < 32'(CHANNELS)) begin
									targets_q[CW'(channel)] <= target;
									changed_q <= 1'b1;
								end
							end
							KIND_RESCHEDULE: pending_q <= 1'b1;
							KIND_EXPIRY: begin
								if (run_q && at_end) begin
									step_q     <= '0;
									gap_q      <= 1'b0;
									cur_time_q <= times_q[0];
									gap_out_q  <= 1'b0;
									set_out_q  <= start_set;
									clr_out_q  <= live_off_q;
									nxt_out_q  <= times_q[0];
								end else if (run_q) begin
									clr_out_q  <= masks_q[step_p1];
									nxt_out_q  <= nxt_time - cur_time_q;
									step_q     <= step_p1[TIW-1:0];
									cur_time_q <= nxt_time;
									if (gap_enter) begin
										gap_q     <= 1'b1;
										gap_out_q <= 1'b1;
										if ((auto_q && changed_q) || pending_q) begin
											// Reschedule from the settings as they stand now.
											changed_q     <= 1'b0;
											pending_q     <= 1'b0;
											snap_min_q    <= min_q;
											snap_max_q    <= max_q;
											snap_res_q    <= res_q;
											snap_diff_q   <= 32'(max_q) - 32'(min_q);
											snap_en_q     <= enable_q;
											live_period_q <= period_q;
											live_on_q     <= on_q;
											live_off_q    <= off_q;
											i_q           <= '0;
											state_q       <= ST_MUL;
										end
									end
								end
							end
							KIND_START: begin
								run_q      <= 1'b1;
								step_q     <= '0;
								gap_q      <= 1'b0;
								cur_time_q <= times_q[0];
								gap_out_q  <= 1'b0;
								run_out_q  <= 1'b1;
								set_out_q  <= start_set;
								clr_out_q  <= live_off_q;
								nxt_out_q  <= times_q[0];
							end
							KIND_STOP: begin
								run_q     <= 1'b0;
								gap_q     <= 1'b0;
								gap_out_q <= 1'b0;
								run_out_q <= 1'b0;
								clr_out_q <= SERVO_PINS;
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					p_q       <= prod;
					rem_q     <= 16'd0;
					div_cnt_q <= '0;
					state_q   <= (snap_res_q == 16'd0) ? ST_STORE : ST_DIV;
				end
				ST_DIV: begin
					// One restoring step; the quotient bit shifts into the dividend.
					rem_q     <= div_ge ? rem_sub[15:0] : rem_n[15:0];
					p_q       <= {p_q[30:0], div_ge};
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					times_q[i_q[TIW-1:0]] <= width_w;
					masks_q[i_q + MIW'(1)] <= 16'(32'd1 << (32'(i_q) + PIN_SHIFT));
					if (i_q == LAST_CH) begin
						times_q[CHANNELS]   <= live_period_q;
						masks_q[CHANNELS+1] <= SERVO_PINS;
						i_q   <= '0;
						top_q <= LAST_CH;
						state_q <= (CHANNELS > 1) ? ST_SORT : ST_GATE;
					end else begin
						i_q     <= i_q + MIW'(1);
						state_q <= ST_MUL;
					end
				end
				ST_SORT: begin
					if (swap) begin
						times_q[i_q[TIW-1:0]]         <= times_q[TIW'(i_q + MIW'(1))];
						times_q[TIW'(i_q + MIW'(1))]  <= times_q[i_q[TIW-1:0]];
						masks_q[i_q + MIW'(1)]        <= masks_q[i_q + MIW'(2)];
						masks_q[i_q + MIW'(2)]        <= masks_q[i_q + MIW'(1)];
					end
					if (i_q + MIW'(1) == top_q) begin
						if (top_q == MIW'(1)) begin
							i_q     <= LAST_CH;
							state_q <= ST_MERGE;
						end else begin
							top_q <= top_q - MIW'(1);
							i_q   <= '0;
						end
					end else begin
						i_q <= i_q + MIW'(1);
					end
				end
				ST_MERGE: begin
					// Equal neighbors fold into one edge and the tail moves down one place.
					if (times_q[TIW'(i_q - MIW'(1))] == times_q[i_q[TIW-1:0]]) begin
						masks_q[i_q] <= masks_q[i_q] + masks_q[i_q + MIW'(1)];
						for (int j = 0; j < CHANNELS; j++) begin
							if (MIW'(j) >= i_q) begin
								times_q[j]   <= times_q[j+1];
								masks_q[j+1] <= masks_q[j+2];
							end
						end
					end
					if (i_q == MIW'(1)) begin
						state_q <= ST_GATE;
					end else begin
						i_q <= i_q - MIW'(1);
					end
				end
				ST_GATE: begin
					masks_q[0] <= 16'(32'(snap_en_q) << PIN_SHIFT);
					for (int k = 1; k <= CHANNELS; k++) begin
						masks_q[k] <= masks_q[k] & 16'(32'(snap_en_q) << PIN_SHIFT);
					end
					cur_time_q <= times_q[step_q];
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MSPS_ASSERT_NEXT(a_accept_gives_word, accept, out_valid_q, "accepted word produced no result")
	`MSPS_ASSERT_NOW(a_gap_needs_run, gap_q, run_q, "gap flag set while stopped")
	`MSPS_ASSERT_NOW(a_step_in_range, 1'b1, step_q <= NCH, "edge step beyond edge list")
	`MSPS_ASSERT_NOW(a_busy_stalls, state_q != ST_IDLE, !in_ready, "input ready during reschedule")

endmodule

// File: verif/tb_multi_servo_pulse_scheduler.sv
// Self-checking testbench for the multichannel servo pulse scheduler.
// Depends on msps_pkg and the scheduler RTL; holds its own predictor of edges and pins.
module tb_multi_servo_pulse_scheduler;
	import msps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = 8;
	localparam logic [2:0] KIND_SPARE  = 3'd5;
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  channel;
		logic [15:0] target;
	} event_word_t;

	typedef struct packed {
		logic [15:0] pins_set;
		logic [15:0] pins_clear;
		logic [15:0] next_interval;
		logic        in_gap;
		logic        running;
	} pin_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] kind = '0;
	logic [2:0] channel = '0;
	logic [15:0] target = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] pins_set, pins_clear, next_interval;
	logic in_gap, running;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	multi_servo_pulse_scheduler #(.CHANNELS(NCH)) u_dut (.*);

	// Predictor state: register file, latched copies, targets and the edge table.
	logic [15:0] reg_file [0:7];
	logic [15:0] servo_target [0:NCH-1];
	logic [15:0] edge_time [0:NCH];
	logic [15:0] edge_mask [0:NCH+1];
	logic [3:0]  edge_idx;
	logic run_st, gap_st, targets_dirty, resched_req;
	logic [15:0] live_period, live_on, live_off;

	event_word_t pending_words[$];
	pin_word_t   expected_pins[$];
	int n_errors = 0, n_items = 0, n_results = 0, n_reschedules = 0, n_phases = 0;
	int unsigned cyc = 0;
	logic quiet;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void rebuild_edges();
		logic [31:0] diff;
		logic [63:0] prod, sum;
		logic [15:0] w, t;
		diff = 32'(reg_file[REG_MAX_PULSE]) - 32'(reg_file[REG_MIN_PULSE]);
		for (int i = 0; i < NCH; i++) begin
			if (reg_file[REG_RESOLUTION] == 16'd0) begin
				w = reg_file[REG_MAX_PULSE];
			end else begin
				prod = (64'(servo_target[i]) * 64'(diff)) & 64'hFFFF_FFFF;
				sum = (prod / 64'(reg_file[REG_RESOLUTION]) + 64'(reg_file[REG_MIN_PULSE]))
					& 64'hFFFF;
				w = sum[15:0];
				if (w > reg_file[REG_MAX_PULSE]) w = reg_file[REG_MAX_PULSE];
			end
			edge_time[i] = w;
			edge_mask[i+1] = 16'(32'd1 << (i + PIN_SHIFT));
		end
		for (int top = NCH - 1; top > 0; top--) begin
			for (int i = 0; i < top; i++) begin
				if (edge_time[i] > edge_time[i+1]) begin
					t = edge_time[i]; edge_time[i] = edge_time[i+1]; edge_time[i+1] = t;
					t = edge_mask[i+1]; edge_mask[i+1] = edge_mask[i+2]; edge_mask[i+2] = t;
				end
			end
		end
		edge_time[NCH] = reg_file[REG_PERIOD];
		edge_mask[NCH+1] = SERVO_PINS;
		// Equal widths collapse into one edge; the tail shifts down by one slot.
		for (int i = NCH - 1; i > 0; i--) begin
			if (edge_time[i-1] == edge_time[i]) begin
				edge_mask[i] = edge_mask[i] + edge_mask[i+1];
				for (int j = i; j < NCH; j++) begin
					edge_time[j] = edge_time[j+1];
					edge_mask[j+1] = edge_mask[j+2];
				end
			end
		end
		edge_mask[0] = {reg_file[REG_ENABLE][7:0], 8'h00};
		for (int i = 1; i <= NCH; i++) edge_mask[i] &= edge_mask[0];
		live_period = reg_file[REG_PERIOD];
		live_on = reg_file[REG_ALWAYS_ON];
		live_off = reg_file[REG_ALWAYS_OFF];
		targets_dirty = 1'b0;
		resched_req = 1'b0;
		n_reschedules++;
	endfunction

	function automatic pin_word_t begin_cycle();
		pin_word_t r;
		r = '0;
		edge_idx = '0;
		gap_st = 1'b0;
		r.pins_clear = live_off;
		r.pins_set = (edge_mask[0] | live_on) & ~live_off;
		r.next_interval = edge_time[0];
		return r;
	endfunction

	function automatic pin_word_t predict_pins(event_word_t w);
		pin_word_t r;
		r = '0;
		case (w.kind)
			KIND_SET_TARGET: begin
				servo_target[w.channel] = w.target;
				targets_dirty = 1'b1;
			end
			KIND_RESCHEDULE: resched_req = 1'b1;
			KIND_EXPIRY: begin
				if (run_st) begin
					if (gap_st || edge_idx >= NCH || edge_time[edge_idx] >= live_period) begin
						r = begin_cycle();
					end else begin
						r.pins_clear = edge_mask[edge_idx+1];
						r.next_interval = edge_time[edge_idx+1] - edge_time[edge_idx];
						edge_idx++;
						if (edge_idx >= NCH || edge_time[edge_idx] >= live_period) begin
							gap_st = 1'b1;
							if ((reg_file[REG_AUTO_APPLY][0] && targets_dirty) || resched_req)
								rebuild_edges();
						end
					end
				end
			end
			KIND_START: begin
				run_st = 1'b1;
				r = begin_cycle();
			end
			KIND_STOP: begin
				run_st = 1'b0;
				gap_st = 1'b0;
				r.pins_clear = SERVO_PINS;
			end
			default: ;
		endcase
		r.in_gap = gap_st;
		r.running = run_st;
		return r;
	endfunction

	// Random idle stretches and backpressure are switched off during a recurring quiet window.
	always @(posedge clk) begin
		cyc <= cyc + 1;
	end
	assign quiet = (cyc % 20000) < 4000;

	// Word driver: payload holds until accepted, prediction happens at acceptance.
	always @(posedge clk) begin
		event_word_t w;
		if (in_valid && in_ready) begin
			expected_pins.push_back(predict_pins('{kind, channel, target}));
			n_items++;
		end
		if (in_valid && !in_ready) begin
			in_valid <= 1'b1;
		end else if (pending_words.size() > 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
			w = pending_words.pop_front();
			in_valid <= 1'b1;
			kind <= w.kind;
			channel <= w.channel;
			target <= w.target;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result monitor with random backpressure.
	always @(posedge clk) begin
		pin_word_t got, want;
		if (out_valid && out_ready) begin
			got = '{pins_set, pins_clear, next_interval, in_gap, running};
			n_results++;
			if (expected_pins.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result word %h", $time, got);
			end else begin
				want = expected_pins.pop_front();
				if (got.pins_set !== want.pins_set)
					$display("%0t: pins_set exp %h got %h", $time, want.pins_set, got.pins_set);
				if (got.pins_clear !== want.pins_clear)
					$display("%0t: pins_clear exp %h got %h", $time, want.pins_clear,
						got.pins_clear);
				if (got.next_interval !== want.next_interval)
					$display("%0t: next_interval exp %0d got %0d", $time, want.next_interval,
						got.next_interval);
				if (got.in_gap !== want.in_gap)
					$display("%0t: in_gap exp %b got %b", $time, want.in_gap, got.in_gap);
				if (got.running !== want.running)
					$display("%0t: running exp %b got %b", $time, want.running, got.running);
				if (got !== want) n_errors++;
			end
		end
		out_ready <= quiet || ($urandom_range(0, 99) >= 10);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		reg_file[idx] = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_word(input logic [2:0] k, input logic [2:0] ch, input logic [15:0] t);
		pending_words.push_back('{k, ch, t});
	endtask

	task automatic wait_idle();
		while (pending_words.size() > 0 || in_valid || expected_pins.size() > 0)
			@(posedge clk);
		// A reschedule may still be running after the last word has come out.
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_target();
		if ($urandom_range(0, 99) < 70)
			return 16'($urandom_range(0, reg_file[REG_RESOLUTION]));
		return 16'($urandom);
	endfunction

	task automatic push_random_burst();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			repeat ($urandom_range(1, 12)) push_word(KIND_EXPIRY, 3'($urandom), 16'($urandom));
		end else if (r < 75) begin
			push_word(KIND_SET_TARGET, 3'($urandom), pick_target());
		end else if (r < 83) begin
			push_word(KIND_RESCHEDULE, 3'($urandom), 16'($urandom));
		end else if (r < 88) begin
			push_word(KIND_START, 3'($urandom), 16'($urandom));
		end else if (r < 93) begin
			push_word(KIND_STOP, 3'($urandom), 16'($urandom));
		end else if (r < 96) begin
			push_word(3'($urandom_range(5, 7)), 3'($urandom), 16'($urandom));
		end else begin
			push_word(3'($urandom), 3'($urandom), 16'($urandom));
		end
	endtask

	task automatic load_settings(input int ph);
		logic [15:0] v [0:7];
		case (ph % 6)
			1: v = '{16'd1, 16'd0, 16'd0, 16'd1, 16'h00, 16'h0000, 16'h0000, 16'd0};
			2: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF, 16'hFFFF, 16'h0000, 16'd1};
			3: v = '{16'd1500, 16'd1800, 16'd900, 16'd0, 16'hA5, 16'h00F0, 16'h0F3C, 16'd1};
			4: v = '{16'd2500, 16'd500, 16'd2400, 16'd4, 16'h5A, 16'hFF00, 16'hFFFF, 16'd0};
			default: begin
				v[REG_PERIOD] = 16'($urandom_range(1, 65535));
				v[REG_MIN_PULSE] = 16'($urandom);
				v[REG_MAX_PULSE] = 16'($urandom);
				v[REG_RESOLUTION] = 16'($urandom_range(1, 1024));
				v[REG_ENABLE] = 16'($urandom_range(0, 255));
				v[REG_ALWAYS_ON] = 16'($urandom);
				v[REG_ALWAYS_OFF] = 16'($urandom);
				v[REG_AUTO_APPLY] = 16'($urandom_range(0, 1));
			end
		endcase
		for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
	endtask

	initial begin
		reg_file[REG_PERIOD] = RST_PERIOD;
		reg_file[REG_MIN_PULSE] = RST_MIN_PULSE;
		reg_file[REG_MAX_PULSE] = RST_MAX_PULSE;
		reg_file[REG_RESOLUTION] = RST_RESOLUTION;
		reg_file[REG_ENABLE] = {8'h00, RST_ENABLE};
		reg_file[REG_ALWAYS_ON] = '0;
		reg_file[REG_ALWAYS_OFF] = '0;
		reg_file[REG_AUTO_APPLY] = '0;
		for (int i = 0; i < NCH; i++) servo_target[i] = '0;
		edge_idx = '0;
		run_st = 1'b0;
		gap_st = 1'b0;
		rebuild_edges();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: a full cycle on reset settings, field extremes and each corner case.
		push_word(KIND_EXPIRY, 3'd0, 16'd0);
		push_word(KIND_RESCHEDULE, 3'd0, 16'd0);
		push_word(KIND_START, 3'd7, 16'hFFFF);
		push_word(KIND_SET_TARGET, 3'd0, 16'hFFFF);
		push_word(KIND_SET_TARGET, 3'd7, 16'd0);
		push_word(KIND_SET_TARGET, 3'd3, 16'd256);
		push_word(KIND_RESCHEDULE, 3'd5, 16'h1234);
		repeat (3) push_word(KIND_EXPIRY, 3'd0, 16'd0);
		push_word(KIND_START, 3'd0, 16'd0);
		repeat (4) push_word(KIND_EXPIRY, 3'd0, 16'd0);
		push_word(KIND_UNUSED, 3'd7, 16'hFFFF);
		push_word(KIND_SPARE, 3'd2, 16'h8000);
		push_word(KIND_STOP, 3'd0, 16'd0);
		push_word(KIND_EXPIRY, 3'd0, 16'd0);
		push_word(KIND_RESCHEDULE, 3'd0, 16'd0);
		push_word(KIND_START, 3'd0, 16'd0);
		repeat (3) push_word(KIND_EXPIRY, 3'd0, 16'd0);
		wait_idle();

		for (int ph = 1; ph <= 8; ph++) begin
			load_settings(ph);
			n_phases++;
			push_word(KIND_RESCHEDULE, 3'd0, 16'd0);
			push_word(KIND_START, 3'd0, 16'd0);
			while (pending_words.size() < 160) push_random_burst();
			wait_idle();
		end

		$display("Ran %0d event words through %0d register settings, %0d results checked,",
			n_items, n_phases + 1, n_results);
		$display("%0d edge table rebuilds predicted, %0d mismatching words.",
			n_reschedules, n_errors);
		if (n_errors == 0) begin
			$display("multi_servo_pulse_scheduler regression: pass");
		end else begin
			$display("multi_servo_pulse_scheduler regression: fail");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Timed out with %0d words still expected.", expected_pins.size());
		$display("multi_servo_pulse_scheduler regression: fail");
		$finish;
	end

endmodule
